FILE: rtl/lst_pkg.sv
package lst_pkg;

  localparam int CHUNK_W = 64;
  localparam int LINE_W  = 25;
  localparam int SEL_W   = 10;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int ST_W    = 3;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_ADD    = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_READ   = 3'd3,
    OP_CHECK  = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DEFINED = 3'd2,
    ST_MISS    = 3'd3,
    ST_RANGE   = 3'd4
  } st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_SCAN,
    S_RDQ,
    S_FIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic ready;
    logic accept;
    logic store_chunk;
    logic norm;
    logic scan;
    logic rd;
    logic fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic full;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/lst_ctrl.sv
module lst_ctrl
  import lst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [2:0] in_op,
  input  logic       in_last,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t     state_r, state_nxt;
  logic [2:0] op_r;
  logic       accept;

  assign accept = in_tvalid && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_CLEAR;
    end else begin
      state_r <= state_nxt;
      if (accept) op_r <= in_op;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_CLEAR:          state_nxt = S_FIN;
            OP_ADD, OP_LOOKUP: state_nxt = in_last ? S_NORM : S_IDLE;
            OP_READ:           state_nxt = S_RDQ;
            OP_CHECK:          state_nxt = S_SCAN;
            default:           state_nxt = S_IDLE;
          endcase
        end
      end
      S_NORM:  state_nxt = (op_r == OP_ADD && stat.full) ? S_FIN : S_SCAN;
      S_SCAN:  state_nxt = stat.scan_done ? S_FIN : S_SCAN;
      S_RDQ:   state_nxt = S_FIN;
      S_FIN:   state_nxt = S_EMIT;
      S_EMIT:  state_nxt = stat.out_free ? S_IDLE : S_EMIT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.ready       = (state_r == S_IDLE);
    cmd.accept      = accept;
    cmd.store_chunk = accept && (in_op == OP_ADD || in_op == OP_LOOKUP);
    cmd.norm        = (state_r == S_NORM);
    cmd.scan        = (state_r == S_SCAN);
    cmd.rd          = (state_r == S_RDQ);
    cmd.fin         = (state_r == S_FIN);
    cmd.emit        = (state_r == S_EMIT);
  end

endmodule

FILE: rtl/lst_datapath.sv
module lst_datapath
  import lst_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int NAME_BYTES  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [2:0]         in_op,
  input  logic [CHUNK_W-1:0] in_chunk,
  input  logic [LINE_W-1:0]  in_line,
  input  logic [SEL_W-1:0]   in_sel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ST_W-1:0]    out_status,
  output logic [IDX_W-1:0]   out_index,
  output logic [LINE_W-1:0]  out_line,
  output logic [CNT_W-1:0]   out_count
);

  localparam int NCH = NAME_BYTES / 8;
  localparam int KW  = NAME_BYTES * 8;
  localparam int IW  = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int PW  = $clog2(NCH + 1);

  logic [KW-1:0]     name_mem [MAX_ENTRIES];
  logic [LINE_W-1:0] line_mem [MAX_ENTRIES];

  logic [KW-1:0]     key_r, key_norm, name_rd;
  logic [PW-1:0]     pos_r;
  logic [CW-1:0]     total_r, scan_i_r;
  logic              pend_r, found_r, bad_r, out_valid_r;
  logic [IW-1:0]     pend_idx_r, f_r, last_bad_r, waddr, raddr;
  logic [LINE_W-1:0] fline_r, line_rd, line_r;
  logic [2:0]        op_r;
  logic [SEL_W-1:0]  sel_r;
  logic              chk, issue, hit, bad_hit, full, oor, ended;
  logic              name_we, line_we, is_add;
  logic [ST_W-1:0]   res_st_r, res_st_nxt, out_st_r;
  logic [IDX_W-1:0]  res_idx_r, res_idx_nxt, out_idx_r;
  logic [LINE_W-1:0] res_line_r, res_line_nxt, out_line_r;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt, out_cnt_r;
  logic              out_free;

  assign chk      = (op_r == OP_CHECK);
  assign full     = 32'(total_r) >= MAX_ENTRIES;
  assign issue    = cmd.scan && (scan_i_r < total_r);
  assign hit      = cmd.scan && pend_r && !chk && (name_rd == key_r);
  assign bad_hit  = cmd.scan && pend_r && chk && (line_rd == '1);
  assign oor      = (32'(sel_r) >= 32'(total_r)) || (32'(sel_r) >= MAX_ENTRIES);
  assign out_free = !out_valid_r || out_ready;
  assign is_add   = cmd.fin && (op_r == OP_ADD) && !full;
  assign name_we  = is_add && !found_r;
  assign line_we  = is_add && (!found_r || fline_r[LINE_W-1]);
  assign waddr    = found_r ? f_r : total_r[IW-1:0];
  assign raddr    = cmd.rd ? IW'(sel_r) : scan_i_r[IW-1:0];

  assign stat.scan_done = hit || (cmd.scan && !pend_r && !issue);
  assign stat.full      = full;
  assign stat.out_free  = out_free;

  always_comb begin
    ended    = 1'b0;
    key_norm = '0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (key_r[b*8 +: 8] == 8'd0) ended = 1'b1;
      key_norm[b*8 +: 8] = ended ? 8'd0 : key_r[b*8 +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (name_we) name_mem[waddr] <= key_r;
    name_rd <= name_mem[scan_i_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (line_we) line_mem[waddr] <= line_r;
    line_rd <= line_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      pos_r       <= '0;
      key_r       <= '0;
      scan_i_r    <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        scan_i_r <= '0;
        pend_r   <= 1'b0;
        found_r  <= 1'b0;
        bad_r    <= 1'b0;
      end
      if (cmd.store_chunk && 32'(pos_r) < NCH) begin
        key_r[pos_r*CHUNK_W +: CHUNK_W] <= in_chunk;
        pos_r <= pos_r + PW'(1);
      end
      if (cmd.norm) key_r <= key_norm;
      if (cmd.scan) begin
        pend_r <= issue;
        if (issue) scan_i_r <= scan_i_r + CW'(1);
        if (hit) found_r <= 1'b1;
        if (bad_hit) bad_r <= 1'b1;
      end
      if (cmd.fin) begin
        case (op_r)
          OP_CLEAR: begin
            total_r <= '0;
            key_r   <= '0;
            pos_r   <= '0;
          end
          OP_ADD, OP_LOOKUP: begin
            if (name_we) total_r <= total_r + CW'(1);
            key_r <= '0;
            pos_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.emit && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    res_st_nxt   = ST_OK;
    res_idx_nxt  = '0;
    res_line_nxt = '1;
    res_cnt_nxt  = CNT_W'(total_r);
    case (op_r)
      OP_CLEAR: res_cnt_nxt = '0;
      OP_ADD: begin
        if (full) begin
          res_st_nxt = ST_FULL;
        end else if (found_r && !fline_r[LINE_W-1]) begin
          res_st_nxt   = ST_DEFINED;
          res_idx_nxt  = IDX_W'(f_r);
          res_line_nxt = fline_r;
        end else if (found_r) begin
          res_idx_nxt  = IDX_W'(f_r);
          res_line_nxt = line_r;
        end else begin
          res_idx_nxt  = IDX_W'(total_r);
          res_line_nxt = line_r;
          res_cnt_nxt  = CNT_W'(total_r + CW'(1));
        end
      end
      OP_LOOKUP: begin
        if (found_r) begin
          res_idx_nxt  = IDX_W'(f_r);
          res_line_nxt = fline_r;
        end else begin
          res_st_nxt = ST_MISS;
        end
      end
      OP_READ: begin
        res_idx_nxt = IDX_W'(sel_r);
        if (oor) res_st_nxt = ST_RANGE;
        else res_line_nxt = line_rd;
      end
      OP_CHECK: begin
        res_st_nxt  = bad_r ? ST_MISS : ST_OK;
        res_idx_nxt = IDX_W'(last_bad_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= in_op;
      line_r     <= in_line;
      sel_r      <= in_sel;
      last_bad_r <= '0;
    end
    pend_idx_r <= scan_i_r[IW-1:0];
    if (hit) begin
      f_r     <= pend_idx_r;
      fline_r <= line_rd;
    end
    if (bad_hit) last_bad_r <= pend_idx_r;
    if (cmd.fin) begin
      res_st_r   <= res_st_nxt;
      res_idx_r  <= res_idx_nxt;
      res_line_r <= res_line_nxt;
      res_cnt_r  <= res_cnt_nxt;
    end
    if (cmd.emit && out_free) begin
      out_st_r   <= res_st_r;
      out_idx_r  <= res_idx_r;
      out_line_r <= res_line_r;
      out_cnt_r  <= res_cnt_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_st_r;
  assign out_index  = out_idx_r;
  assign out_line   = out_line_r;
  assign out_count  = out_cnt_r;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= MAX_ENTRIES)
    else $error("entry total beyond table size");

  a_found_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && found_r) |-> (32'(f_r) < 32'(total_r)))
    else $error("found entry outside filled part");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && op_r == OP_CLEAR) |=> (total_r == '0 && pos_r == '0))
    else $error("clear left entries behind");

endmodule

FILE: rtl/label_symbol_table_unit.sv
// label table for a program loader
// in channel: in_tuser carries the operation, in_tlast ends a name, in_tdata
// carries name chunk, line number and entry select
// out channel: out_tuser carries the status, out_tdata index, line and count
// one item at a time; in_tready is high whenever no item is in progress
// clear goes through the finish and emit states; read by index goes through read, finish and emit
// name chunks without tlast are taken and give no result
// add and lookup scan the name memory one entry a cycle, up to the entry count
// check scans the line memory the same way
// a full table on add skips the scan
// a result waits in the output register while the receiver stalls; the
// next item may still be taken and holds its result until the slot frees
// reset empties the table and the partial name; stored names and lines keep
// stale contents, never read beyond the entry count
module label_symbol_table_unit
  import lst_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int NAME_BYTES  = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // name_chunk, line, entry_select
  input  logic [2:0]   in_tuser,  // operation
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata, // entry_index, line_value, entry_count
  output logic [2:0]   out_tuser  // status
);

  cmd_t  cmd;
  stat_t stat;

  lst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_last   (in_tlast),
    .stat      (stat),
    .cmd       (cmd)
  );

  logic [IDX_W-1:0]  out_index;
  logic [LINE_W-1:0] out_line;
  logic [CNT_W-1:0]  out_count;

  lst_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .NAME_BYTES  (NAME_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_tuser),
    .in_chunk   (in_tdata[63:0]),
    .in_line    (in_tdata[88:64]),
    .in_sel     (in_tdata[98:89]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_index  (out_index),
    .out_line   (out_line),
    .out_count  (out_count)
  );

  assign in_tready = cmd.ready;
  assign out_tdata = {2'b00, out_count, out_line, out_index};

endmodule
